@@ rtl/core/fpe_pkg.sv @@
// -----------------------------------------------------------------------------
// fpe_pkg
// Shared types and constants of the frustum plane extraction core.
// -----------------------------------------------------------------------------
package fpe_pkg;

    // Fraction bits of a unit normal component
    localparam int NORM_FRAC = 30;

    // Plane codes
    localparam logic [2:0] PLANE_LEFT   = 3'd0;
    localparam logic [2:0] PLANE_RIGHT  = 3'd1;
    localparam logic [2:0] PLANE_BOTTOM = 3'd2;
    localparam logic [2:0] PLANE_TOP    = 3'd3;
    localparam logic [2:0] PLANE_NEAR   = 3'd4;
    localparam logic [2:0] PLANE_FAR    = 3'd5;

    // One plane handed from front to back: exact 33-bit row sums
    typedef struct packed {
        logic [2:0]       plane;
        logic [3:0][32:0] sum;
    } plane_job_t;

endpackage

@@ rtl/core/fpe_front.sv @@
// -----------------------------------------------------------------------------
// fpe_front
// Stores matrix rows and, after the last row, forms the six plane sums.
// -----------------------------------------------------------------------------
module fpe_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         row_index,
    input  logic signed [31:0] elem_c0,
    input  logic signed [31:0] elem_c1,
    input  logic signed [31:0] elem_c2,
    input  logic signed [31:0] elem_c3,
    input  logic               last_row,
    input  logic               queue_full,
    output logic               job_push,
    output fpe_pkg::plane_job_t job,
    output logic               active
);
    import fpe_pkg::*;

    logic [31:0] row_mem [4][4];
    logic        active_reg, active_next;
    logic [2:0]  plane_reg, plane_next;
    logic [1:0]  k;
    logic        minus;

    // Write the row of each transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_mem[row_index][0] <= elem_c0;
            row_mem[row_index][1] <= elem_c1;
            row_mem[row_index][2] <= elem_c2;
            row_mem[row_index][3] <= elem_c3;
        end
    end

    // Form row 3 plus or minus row k
    assign k     = plane_reg[2:1];
    assign minus = plane_reg[0];

    always_comb
    begin
        job.plane = plane_reg;
        for (int c = 0; c < 4; c++)
        begin
            if (minus)
                job.sum[c] = {row_mem[3][c][31], row_mem[3][c]}
                           - {row_mem[k][c][31], row_mem[k][c]};
            else
                job.sum[c] = {row_mem[3][c][31], row_mem[3][c]}
                           + {row_mem[k][c][31], row_mem[k][c]};
        end
    end

    assign job_push = active_reg && !queue_full;
    assign active   = active_reg;

    // Advance through the six planes
    always_comb
    begin
        active_next = active_reg;
        plane_next  = plane_reg;
        if (accept && last_row)
        begin
            active_next = 1'b1;
            plane_next  = PLANE_LEFT;
        end
        else if (job_push)
        begin
            plane_next = plane_reg + 3'd1;
            if (plane_reg == PLANE_FAR)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            plane_reg  <= PLANE_LEFT;
        end
        else
        begin
            active_reg <= active_next;
            plane_reg  <= plane_next;
        end
    end

endmodule

@@ rtl/core/fpe_queue.sv @@
// -----------------------------------------------------------------------------
// fpe_queue
// Two-entry queue of plane jobs between front and back.
// -----------------------------------------------------------------------------
module fpe_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fpe_pkg::plane_job_t push_job,
    input  logic                pop,
    output fpe_pkg::plane_job_t head_job,
    output logic                full,
    output logic                empty
);
    import fpe_pkg::*;

    plane_job_t  slot_reg [2];
    logic        wr_reg, rd_reg;
    logic [1:0]  count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_job = slot_reg[rd_reg];

    // Hold job payloads
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop && !full |=> !empty)
        else $error("queue count lost a push");

endmodule

@@ rtl/core/fpe_back.sv @@
// -----------------------------------------------------------------------------
// fpe_back
// Normalizes one plane: sum of squares, bit-serial root, then four serial divides unless the root is zero.
// -----------------------------------------------------------------------------
module fpe_back
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_ready,
    input  fpe_pkg::plane_job_t head_job,
    output logic                pop,
    output logic                busy,
    output logic                result_valid,
    output logic [2:0]          plane_index,
    output logic signed [31:0]  normal_x,
    output logic signed [31:0]  normal_y,
    output logic signed [31:0]  normal_z,
    output logic signed [31:0]  plane_distance,
    output logic                degenerate,
    output logic                last_plane
);
    import fpe_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_ROOT  = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_STORE = 3'd5;

    logic [2:0]        state_reg;
    plane_job_t        job_reg;
    logic              big_reg;
    logic [1:0]        col_reg;
    logic [5:0]        cnt_reg;
    logic [63:0]       sum_reg;
    logic [63:0]       res_reg;
    logic [63:0]       bit_reg;
    logic [32:0]       len_reg;
    logic [63:0]       num_reg;
    logic [32:0]       drem_reg;
    logic [63:0]       quo_reg;
    logic [2:0][31:0]  nrm_reg;
    logic              valid_reg;

    logic [3:0][32:0]  mag;
    logic              big;
    logic [1:0]        sq_col;
    logic [31:0]       sq_op;
    logic [63:0]       sq;
    logic [63:0]       root_t;
    logic              root_ok;
    logic [63:0]       root_next;
    logic [32:0]       root_len;
    logic [32:0]       cur_mag;
    logic [63:0]       num_init;
    logic [33:0]       rem_sh;
    logic              q_ok;
    logic              cur_neg;
    logic [31:0]       q_sat;
    logic [32:0]       a3;
    logic [31:0]       d_sat;

    // Magnitudes and range check of the normal
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            mag[c] = job_reg.sum[c][32] ? 33'(-job_reg.sum[c]) : job_reg.sum[c];
    end
    assign big = (mag[0][32:31] != 2'b00) || (mag[1][32:31] != 2'b00)
              || (mag[2][32:31] != 2'b00);

    // Square one component a cycle, normal columns 0..2 on counts 1..3
    assign sq_col = cnt_reg[1:0] - 2'd1;
    assign sq_op  = big_reg ? mag[sq_col][32:1] : mag[sq_col][31:0];
    assign sq     = 64'(sq_op) * 64'(sq_op);

    // One root digit a cycle
    assign root_t    = res_reg + bit_reg;
    assign root_ok   = sum_reg >= root_t;
    assign root_next = root_ok ? (res_reg >> 1) + bit_reg : res_reg >> 1;
    assign root_len  = big_reg ? {root_next[31:0], 1'b0} : {1'b0, root_next[31:0]};

    // Rounded numerator for the current column
    assign cur_mag  = mag[col_reg];
    assign cur_neg  = job_reg.sum[col_reg][32];
    assign num_init = (col_reg == 2'd3)
                    ? (64'(cur_mag) << FRAC_BITS) + 64'(len_reg >> 1)
                    : (64'(cur_mag) << NORM_FRAC) + 64'(len_reg >> 1);

    // One quotient bit a cycle
    assign rem_sh = {drem_reg, num_reg[63]};
    assign q_ok   = rem_sh >= {1'b0, len_reg};

    // Saturate the signed quotient
    always_comb
    begin
        if (cur_neg)
            q_sat = (quo_reg > 64'h8000_0000) ? 32'h8000_0000 : 32'(-quo_reg);
        else
            q_sat = (quo_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_reg[31:0];
    end

    // Saturate the unscaled distance
    assign a3 = job_reg.sum[3];
    always_comb
    begin
        if (a3[32] && !a3[31])
            d_sat = 32'h8000_0000;
        else if (!a3[32] && a3[31])
            d_sat = 32'h7FFF_FFFF;
        else
            d_sat = a3[31:0];
    end

    assign pop  = (state_reg == ST_IDLE) && job_ready;
    assign busy = (state_reg != ST_IDLE);

    // Payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_ready)
                    job_reg <= head_job;
                sum_reg <= '0;
                res_reg <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            ST_SQ:
            begin
                if (cnt_reg == 6'd0)
                    big_reg <= big;
                else
                    sum_reg <= sum_reg + sq;
            end
            ST_ROOT:
            begin
                if (root_ok)
                    sum_reg <= sum_reg - root_t;
                res_reg <= root_next;
                bit_reg <= bit_reg >> 2;
            end
            ST_LOAD:
            begin
                num_reg  <= num_init;
                drem_reg <= '0;
                quo_reg  <= '0;
            end
            ST_DIV:
            begin
                drem_reg <= q_ok ? 33'(rem_sh - {1'b0, len_reg}) : rem_sh[32:0];
                num_reg  <= num_reg << 1;
                quo_reg  <= {quo_reg[62:0], q_ok};
            end
            ST_STORE:
            begin
                if (col_reg != 2'd3)
                    nrm_reg[col_reg] <= q_sat;
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_ROOT && cnt_reg == 6'd31)
            len_reg <= root_len;
    end

    // Sequence the plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            col_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    col_reg <= '0;
                    if (job_ready)
                        state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    if (cnt_reg == 6'd3)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_ROOT;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_ROOT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                    begin
                        cnt_reg <= '0;
                        if (root_len == '0)
                        begin
                            valid_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                            state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                        state_reg <= ST_STORE;
                end
                ST_STORE:
                begin
                    col_reg <= col_reg + 2'd1;
                    if (col_reg == 2'd3)
                    begin
                        valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                        state_reg <= ST_LOAD;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Result registers
    logic        degen_reg;
    logic [31:0] dist_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROOT && cnt_reg == 6'd31 && root_len == '0)
        begin
            degen_reg <= 1'b1;
            dist_reg  <= d_sat;
        end
        else if (state_reg == ST_STORE && col_reg == 2'd3)
        begin
            degen_reg <= 1'b0;
            dist_reg  <= q_sat;
        end
    end

    assign result_valid   = valid_reg;
    assign plane_index    = job_reg.plane;
    assign normal_x       = degen_reg ? '0 : nrm_reg[0];
    assign normal_y       = degen_reg ? '0 : nrm_reg[1];
    assign normal_z       = degen_reg ? '0 : nrm_reg[2];
    assign plane_distance = dist_reg;
    assign degenerate     = degen_reg;
    assign last_plane     = (job_reg.plane == PLANE_FAR);

    a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");
    a_pulse_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> state_reg == ST_IDLE)
        else $error("result shown while back still working");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_SQ)
        else $error("popped job not started");

endmodule

@@ rtl/core/frustum_plane_extract_core.sv @@
// -----------------------------------------------------------------------------
// frustum_plane_extract_core
// Clip plane extraction from a 4x4 matrix, normals scaled to unit length.
// -----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// input    | start, busy          | row_index, elem_c0..elem_c3, last_row
// result   | result_valid strobe  | plane_index, normal_x/y/z, plane_distance,
//          |                      | degenerate, last_plane
//
// A row that is not last is written to the row store when accepted. A last
// row starts six planes; in the back end each passes the idle, square and
// root states, then for each of four columns the load, divide and store
// states of the one bit-serial divider, or ends after the root for a zero
// normal. busy stays high until the last plane's strobe. Reset clears all
// control state; the matrix rows are undefined until written. The receiver
// cannot stall: each result shows for one cycle.
// -----------------------------------------------------------------------------
module frustum_plane_extract_core
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         row_index,
    input  logic signed [31:0] elem_c0,
    input  logic signed [31:0] elem_c1,
    input  logic signed [31:0] elem_c2,
    input  logic signed [31:0] elem_c3,
    input  logic               last_row,
    output logic               result_valid,
    output logic [2:0]         plane_index,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    output logic signed [31:0] normal_z,
    output logic signed [31:0] plane_distance,
    output logic               degenerate,
    output logic               last_plane
);
    import fpe_pkg::*;

    logic       accept;
    logic       front_active;
    logic       job_push;
    plane_job_t push_job;
    plane_job_t head_job;
    logic       queue_full;
    logic       queue_empty;
    logic       pop;
    logic       back_busy;

    assign accept = start && !busy;
    assign busy   = front_active || !queue_empty || back_busy;

    fpe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .row_index  (row_index),
        .elem_c0    (elem_c0),
        .elem_c1    (elem_c1),
        .elem_c2    (elem_c2),
        .elem_c3    (elem_c3),
        .last_row   (last_row),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (push_job),
        .active     (front_active)
    );

    fpe_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    fpe_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_ready      (!queue_empty),
        .head_job       (head_job),
        .pop            (pop),
        .busy           (back_busy),
        .result_valid   (result_valid),
        .plane_index    (plane_index),
        .normal_x       (normal_x),
        .normal_y       (normal_y),
        .normal_z       (normal_z),
        .plane_distance (plane_distance),
        .degenerate     (degenerate),
        .last_plane     (last_plane)
    );

endmodule

@@ dv/tb_frustum_plane_extract_core.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_frustum_plane_extract_core
// Self-checking bench for the frustum plane extraction core: it loads matrix
// rows, predicts the six unit-normal clip planes of every final row and checks
// each plane strobe field by field, under random start gaps.
// -----------------------------------------------------------------------------
module tb_frustum_plane_extract_core;
    import fpe_pkg::*;

    localparam int FRAC     = 16;
    localparam int IDLE_MAX = 4000;

    typedef struct {
        logic [2:0]         plane;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] pdist;
        logic               degen;
        logic               lastp;
    } plane_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         row_index;
    logic signed [31:0] elem_c0;
    logic signed [31:0] elem_c1;
    logic signed [31:0] elem_c2;
    logic signed [31:0] elem_c3;
    logic               last_row;
    logic               result_valid;
    logic [2:0]         plane_index;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] plane_distance;
    logic               degenerate;
    logic               last_plane;

    // Shadow copy of the matrix held by the core
    logic signed [31:0] shadow_rows [4][4];
    bit   [3:0]         rows_loaded;
    plane_t             planes_due [$];
    int                 n_errors;
    int                 n_rows;
    int                 n_planes;
    int                 n_degen;
    int                 idle_cycles;

    frustum_plane_extract_core #(.FRAC_BITS(FRAC)) dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .row_index      (row_index),
        .elem_c0        (elem_c0),
        .elem_c1        (elem_c1),
        .elem_c2        (elem_c2),
        .elem_c3        (elem_c3),
        .last_row       (last_row),
        .result_valid   (result_valid),
        .plane_index    (plane_index),
        .normal_x       (normal_x),
        .normal_y       (normal_y),
        .normal_z       (normal_z),
        .plane_distance (plane_distance),
        .degenerate     (degenerate),
        .last_plane     (last_plane)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Floor square root, bit by bit
    function automatic longint unsigned floor_sqrt(longint unsigned s);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Round v * 2^sh / den half away from zero, saturate to 32 bits
    function automatic logic signed [31:0] div_round_sat(longint v, int sh,
                                                         longint unsigned den);
        longint unsigned m;
        longint unsigned q;
        m = (v < 0) ? longint'(-v) : longint'(v);
        q = ((m << sh) + den / 2) / den;
        if (v < 0)
        begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return -longint'(q);
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] sat_word(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Queue the six planes of the shadow matrix
    task automatic push_clip_planes();
        plane_t          pl;
        longint          a [4];
        longint unsigned m;
        longint unsigned sq;
        longint unsigned len;
        bit              big;
        int              k;
        for (int p = 0; p < 6; p++)
        begin
            k = p / 2;
            for (int c = 0; c < 4; c++)
                a[c] = (p % 2) ? longint'(shadow_rows[3][c]) - longint'(shadow_rows[k][c])
                               : longint'(shadow_rows[3][c]) + longint'(shadow_rows[k][c]);
            big = 1'b0;
            for (int c = 0; c < 3; c++)
                if (a[c] >= 64'sh8000_0000 || a[c] <= -64'sh8000_0000) big = 1'b1;
            sq = 0;
            for (int c = 0; c < 3; c++)
            begin
                m = (a[c] < 0) ? longint'(-a[c]) : longint'(a[c]);
                if (big) m = m >> 1;
                sq = sq + m * m;
            end
            len = floor_sqrt(sq);
            if (big) len = len << 1;
            pl.plane = p[2:0];
            pl.lastp = (p == 5);
            if (len == 0)
            begin
                pl.nx = '0;
                pl.ny = '0;
                pl.nz = '0;
                pl.pdist = sat_word(a[3]);
                pl.degen = 1'b1;
            end
            else
            begin
                pl.nx = div_round_sat(a[0], NORM_FRAC, len);
                pl.ny = div_round_sat(a[1], NORM_FRAC, len);
                pl.nz = div_round_sat(a[2], NORM_FRAC, len);
                pl.pdist = div_round_sat(a[3], FRAC, len);
                pl.degen = 1'b0;
            end
            planes_due.push_back(pl);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    // Send one row after a random gap; hold it until the core takes it
    task automatic send_row(int r, logic signed [31:0] e0, logic signed [31:0] e1,
                            logic signed [31:0] e2, logic signed [31:0] e3, bit lst);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        row_index <= r[1:0];
        elem_c0   <= e0;
        elem_c1   <= e1;
        elem_c2   <= e2;
        elem_c3   <= e3;
        last_row  <= lst;
        @(posedge clk);
        while (busy) @(posedge clk);
        shadow_rows[r][0] = e0;
        shadow_rows[r][1] = e1;
        shadow_rows[r][2] = e2;
        shadow_rows[r][3] = e3;
        rows_loaded[r] = 1'b1;
        n_rows++;
        if (lst) push_clip_planes();
    endtask

    // Drop start and wait until every expected plane has come
    task automatic drain_planes();
        start <= 1'b0;
        @(posedge clk);
        while (planes_due.size() != 0) @(posedge clk);
    endtask

    // Check each plane strobe against the oldest expectation
    always @(posedge clk)
    begin
        plane_t want;
        if (rst_n && result_valid)
        begin
            if (planes_due.size() == 0)
                report_mismatch("unexpected plane", plane_index, -1);
            else
            begin
                want = planes_due.pop_front();
                n_planes++;
                if (want.degen) n_degen++;
                if (plane_index !== want.plane)
                    report_mismatch("plane_index", plane_index, want.plane);
                if (normal_x !== want.nx) report_mismatch("normal_x", normal_x, want.nx);
                if (normal_y !== want.ny) report_mismatch("normal_y", normal_y, want.ny);
                if (normal_z !== want.nz) report_mismatch("normal_z", normal_z, want.nz);
                if (plane_distance !== want.pdist)
                    report_mismatch("plane_distance", plane_distance, want.pdist);
                if (degenerate !== want.degen)
                    report_mismatch("degenerate", degenerate, want.degen);
                if (last_plane !== want.lastp)
                    report_mismatch("last_plane", last_plane, want.lastp);
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("tb_frustum_plane_extract_core: errors");
            $finish;
        end
    end

    // Perspective-like matrix, then a drain before the next load
    task automatic test_projection();
        send_row(0, 32'sh0001_0000, 0, 0, 0, 1'b0);
        send_row(1, 0, 32'sh0001_0000, 0, 0, 1'b0);
        send_row(2, 0, 0, -32'sh0001_0000, -32'sh0002_0000, 1'b0);
        send_row(3, 0, 0, -32'sh0001_0000, 0, 1'b1);
        drain_planes();
    endtask

    // Rows with zero normal columns: every plane has a zero normal
    task automatic test_zero_normal();
        send_row(3, 0, 0, 0, 32'sh7FFF_FFFF, 1'b0);
        send_row(0, 0, 0, 0, 32'sh7FFF_FFFF, 1'b0);
        send_row(1, 0, 0, 0, -32'sh8000_0000, 1'b0);
        send_row(2, 0, 0, 0, 32'sh0000_1234, 1'b1);
    endtask

    // Full-scale elements: halved square sums and saturated distances
    task automatic test_extremes();
        send_row(3, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_row(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        send_row(1, 32'sh0000_0001, -1, 0, 32'sh8000_0000, 1'b0);
        send_row(2, 32'sh8000_0000, 32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
        // Tiny normal with large distance saturates both ways
        send_row(3, 1, 0, 0, 32'sh4000_0000, 1'b0);
        send_row(0, 0, 0, 0, 32'sh3FFF_FFFF, 1'b1);
        send_row(1, -1, -1, -1, -32'sh8000_0000, 1'b1);
    endtask

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1:       return 0;
            2:       return $signed($urandom_range(0, 511)) - 256;
            3:       return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly complete matrices in random row order, some stray rows
    task automatic test_random(int n_items);
        int sent;
        int order [4];
        int j;
        int t;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                order = '{0, 1, 2, 3};
                for (int i = 3; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    t = order[i];
                    order[i] = order[j];
                    order[j] = t;
                end
                for (int i = 0; i < 4; i++)
                    send_row(order[i], rand_elem(), rand_elem(), rand_elem(),
                             rand_elem(), i == 3);
                sent += 4;
            end
            else
            begin
                send_row($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom,
                         (rows_loaded == 4'hF) && ($urandom_range(0, 2) == 0));
                sent++;
            end
            if ($urandom_range(0, 15) == 0) drain_planes();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        row_index   = '0;
        elem_c0     = '0;
        elem_c1     = '0;
        elem_c2     = '0;
        elem_c3     = '0;
        last_row    = 1'b0;
        rows_loaded = '0;
        n_errors    = 0;
        n_rows      = 0;
        n_planes    = 0;
        n_degen     = 0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_projection();
        test_zero_normal();
        test_extremes();
        test_random(300);

        drain_planes();
        repeat (400) @(posedge clk);

        $display("Covered %0d rows, %0d planes checked (%0d with zero normal).",
                 n_rows, n_planes, n_degen);
        if (n_errors == 0)
            $display("tb_frustum_plane_extract_core: clean");
        else
            $display("tb_frustum_plane_extract_core: errors");
        $finish;
    end

endmodule
